FILE: design/tfr_pkg.sv
package tfr_pkg;

   localparam int unsigned PollWidth  = 20;
   localparam int unsigned LenWidth   = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned StatWidth  = 3;
   localparam int unsigned CsrAddrW   = 3;
   localparam int unsigned CsrDataW   = 32;
   localparam int unsigned RspDataW   = 48;

   localparam logic [PollWidth-1:0] PollLimitReset = 20'd1000;
   localparam logic [LenWidth-1:0]  MaxLengthReset = 16'd258;

   // register indexes, selected by paddr[2]
   localparam logic RegPollLimit = 1'b0;
   localparam logic RegMaxLength = 1'b1;

   // link bytes
   localparam logic [7:0] ByteTag   = 8'hAA;
   localparam logic [7:0] ByteUndef = 8'h99;
   localparam logic [7:0] ByteWtag  = 8'hBB;
   localparam logic [7:0] ByteWlen  = 8'hCC;
   localparam logic [7:0] ByteWcrc  = 8'hDD;
   localparam logic [7:0] ByteBusy  = 8'hFF;

   // end status codes
   localparam logic [StatWidth-1:0] StOk      = 3'd0;
   localparam logic [StatWidth-1:0] StBadsum  = 3'd1;
   localparam logic [StatWidth-1:0] StTimeout = 3'd2;
   localparam logic [StatWidth-1:0] StUndef   = 3'd3;
   localparam logic [StatWidth-1:0] StWtag    = 3'd4;
   localparam logic [StatWidth-1:0] StWlen    = 3'd5;
   localparam logic [StatWidth-1:0] StWcrc    = 3'd6;
   localparam logic [StatWidth-1:0] StLong    = 3'd7;

   localparam logic KindPayload = 1'b0;
   localparam logic KindEnd     = 1'b1;

   typedef struct packed {
      logic [PollWidth-1:0] poll_limit;
      logic [LenWidth-1:0]  max_length;
   } cfg_type;

   typedef struct packed {
      logic                 out_kind;
      logic [ByteWidth-1:0] payload_byte;
      logic [LenWidth-1:0]  payload_index;
      logic [StatWidth-1:0] status;
      logic [LenWidth-1:0]  frame_length;
   } result_type;

endpackage

FILE: design/tfr_csr.sv
module tfr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tfr_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [tfr_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [tfr_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready,
   output tfr_pkg::cfg_type              cfg
);

   logic [tfr_pkg::PollWidth-1:0] poll_limit_ff;
   logic [tfr_pkg::LenWidth-1:0]  max_length_ff;
   logic                          wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= tfr_pkg::PollLimitReset;
         max_length_ff <= tfr_pkg::MaxLengthReset;
      end else if (wr_en) begin
         if (csr_paddr[2] == tfr_pkg::RegPollLimit) begin
            poll_limit_ff <= csr_pwdata[tfr_pkg::PollWidth-1:0];
         end else begin
            max_length_ff <= csr_pwdata[tfr_pkg::LenWidth-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == tfr_pkg::RegPollLimit) begin
         csr_prdata = {{(tfr_pkg::CsrDataW-tfr_pkg::PollWidth){1'b0}}, poll_limit_ff};
      end else begin
         csr_prdata = {{(tfr_pkg::CsrDataW-tfr_pkg::LenWidth){1'b0}}, max_length_ff};
      end
   end

   assign cfg.poll_limit = poll_limit_ff;
   assign cfg.max_length = max_length_ff;

endmodule

FILE: design/tfr_parser.sv
module tfr_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  tfr_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [tfr_pkg::ByteWidth-1:0]  in_byte,
   output logic                           out_valid,
   input  logic                           out_ready,
   output tfr_pkg::result_type            out_result
);

   localparam logic [2:0] PhHunt  = 3'd0;
   localparam logic [2:0] PhLenHi = 3'd1;
   localparam logic [2:0] PhLenLo = 3'd2;
   localparam logic [2:0] PhData  = 3'd3;
   localparam logic [2:0] PhCheck = 3'd4;

   // input register
   logic                          in_valid_ff;
   logic [tfr_pkg::ByteWidth-1:0] in_byte_ff;

   // frame state
   logic [2:0]                    phase_ff, phase_in;
   logic [tfr_pkg::PollWidth-1:0] polls_left_ff, polls_left_in;
   logic [tfr_pkg::LenWidth-1:0]  frame_len_ff, frame_len_in;
   logic [tfr_pkg::LenWidth-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [tfr_pkg::ByteWidth-1:0] running_xor_ff, running_xor_in;

   // result register
   logic                          out_valid_ff;
   tfr_pkg::result_type           result_ff, result_in;
   logic                          emit;

   logic                          advance;
   logic [tfr_pkg::PollWidth-1:0] polls_eff;
   logic [tfr_pkg::PollWidth-1:0] polls_dec;
   logic [tfr_pkg::LenWidth-1:0]  len_full;
   logic [tfr_pkg::LenWidth-1:0]  seen_inc;
   logic [tfr_pkg::ByteWidth-1:0] b;

   assign advance  = in_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !in_valid_ff || advance;
   assign b        = in_byte_ff;

   // budget is loaded at the first hunt byte; a zero limit counts as one
   always_comb begin
      if (polls_left_ff != '0) begin
         polls_eff = polls_left_ff;
      end else if (cfg.poll_limit == '0) begin
         polls_eff = {{(tfr_pkg::PollWidth-1){1'b0}}, 1'b1};
      end else begin
         polls_eff = cfg.poll_limit;
      end
   end

   assign polls_dec = polls_eff - 1'b1;
   assign len_full  = {frame_len_ff[tfr_pkg::LenWidth-1:8], b};
   assign seen_inc  = bytes_seen_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      polls_left_in  = polls_left_ff;
      frame_len_in   = frame_len_ff;
      bytes_seen_in  = bytes_seen_ff;
      running_xor_in = running_xor_ff;
      emit           = 1'b0;
      result_in      = '0;
      result_in.out_kind = tfr_pkg::KindEnd;

      unique case (phase_ff)
         PhHunt: begin
            priority if (b == tfr_pkg::ByteTag) begin
               phase_in      = PhLenHi;
               polls_left_in = '0;
               frame_len_in  = '0;
            end else if (b == tfr_pkg::ByteUndef) begin
               emit             = 1'b1;
               result_in.status = tfr_pkg::StUndef;
            end else if (b == tfr_pkg::ByteWtag) begin
               emit             = 1'b1;
               result_in.status = tfr_pkg::StWtag;
            end else if (b == tfr_pkg::ByteWlen) begin
               emit             = 1'b1;
               result_in.status = tfr_pkg::StWlen;
            end else if (b == tfr_pkg::ByteWcrc) begin
               emit             = 1'b1;
               result_in.status = tfr_pkg::StWcrc;
            end else begin
               // busy and unknown bytes burn one poll
               polls_left_in = polls_dec;
               if (polls_dec == '0) begin
                  emit             = 1'b1;
                  result_in.status = tfr_pkg::StTimeout;
               end
            end
         end
         PhLenHi: begin
            frame_len_in = {b, 8'h00};
            phase_in     = PhLenLo;
         end
         PhLenLo: begin
            frame_len_in = len_full;
            if (len_full > cfg.max_length) begin
               emit                   = 1'b1;
               result_in.status       = tfr_pkg::StLong;
               result_in.frame_length = len_full;
            end else begin
               bytes_seen_in  = '0;
               running_xor_in = '0;
               phase_in       = (len_full == '0) ? PhCheck : PhData;
            end
         end
         PhData: begin
            emit                    = 1'b1;
            result_in.out_kind      = tfr_pkg::KindPayload;
            result_in.payload_byte  = b;
            result_in.payload_index = bytes_seen_ff;
            result_in.frame_length  = frame_len_ff;
            running_xor_in          = running_xor_ff ^ b;
            bytes_seen_in           = seen_inc;
            if (seen_inc >= frame_len_ff) begin
               phase_in = PhCheck;
            end
         end
         PhCheck: begin
            emit                   = 1'b1;
            result_in.status       = (b == running_xor_ff) ? tfr_pkg::StOk
                                                           : tfr_pkg::StBadsum;
            result_in.frame_length = frame_len_ff;
         end
         default: begin
            phase_in       = PhHunt;
            polls_left_in  = '0;
            bytes_seen_in  = '0;
            running_xor_in = '0;
         end
      endcase

      // every end result sends the block back to hunting
      if (emit && result_in.out_kind == tfr_pkg::KindEnd) begin
         phase_in       = PhHunt;
         polls_left_in  = '0;
         bytes_seen_in  = '0;
         running_xor_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PhHunt;
         polls_left_ff  <= '0;
         frame_len_ff   <= '0;
         bytes_seen_ff  <= '0;
         running_xor_ff <= '0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (advance) begin
            phase_ff       <= phase_in;
            polls_left_ff  <= polls_left_in;
            frame_len_ff   <= frame_len_in;
            bytes_seen_ff  <= bytes_seen_in;
            running_xor_ff <= running_xor_in;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         in_byte_ff <= in_byte;
      end
      if (advance && emit) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

FILE: design/tagged_frame_receiver_unit.sv
// the byte behind a result is held in the input register, and the result then in the result register
// throughput: one byte per cycle; the input stalls only while a result waits at the output
// the frame state machine handles one registered byte per cycle unless a result waits at the output
// reset: synchronous, active high; registers go to 1000 and 258, the block hunts for a tag
module tagged_frame_receiver_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tfr_pkg::RspDataW-1:0]  rsp_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                                      // [26:24] status, [42:27] frame_length
   output logic                          rsp_tuser,   // [0] out_kind
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tfr_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [tfr_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [tfr_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready
);

   tfr_pkg::cfg_type    cfg;
   tfr_pkg::result_type result;

   tfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.out_kind;
   assign rsp_tdata = {5'b0, result.frame_length, result.status,
                       result.payload_index, result.payload_byte};

`ifndef SYNTHESIS
   // payload items always carry status zero and an index inside the frame
   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tfr_pkg::KindPayload) |->
         (rsp_tdata[26:24] == tfr_pkg::StOk && rsp_tdata[23:8] < rsp_tdata[42:27]))
      else $error("payload item with bad status or index");

   // ends before a length is known report no length and no byte
   a_early_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tfr_pkg::KindEnd &&
       (rsp_tdata[26:24] == tfr_pkg::StTimeout || rsp_tdata[26:24] == tfr_pkg::StUndef ||
        rsp_tdata[26:24] == tfr_pkg::StWtag || rsp_tdata[26:24] == tfr_pkg::StWlen ||
        rsp_tdata[26:24] == tfr_pkg::StWcrc)) |->
         (rsp_tdata[42:27] == '0 && rsp_tdata[23:0] == '0))
      else $error("early end item with nonzero fields");

   // the input side stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a blocked result");
`endif

endmodule
